// ===== hw/rtl/sphere_volume_overlap_test_macros.svh =====
// Assertion helpers for the sphere overlap test.
// Each macro expects clk and rst_n in scope.
`ifndef SPHERE_VOLUME_OVERLAP_TEST_MACROS_SVH
`define SPHERE_VOLUME_OVERLAP_TEST_MACROS_SVH

// cond at an edge implies res at the same edge
`define SVOT_ASSERT_NOW(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
    else $error(msg);

// cond at an edge implies res at the following edge
`define SVOT_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error(msg);

`endif

// ===== hw/rtl/svot_pkg.sv =====
package svot_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  // Query kinds
  localparam logic ACT_BOX    = 1'b0;
  localparam logic ACT_SPHERE = 1'b1;

  // Number of register stages, output register included
  localparam int NUM_STAGES = 6;

  localparam int NUM_AXES = 3;

endpackage

// ===== hw/rtl/sphere_volume_overlap_test.sv =====
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ----------------------------
// input     in_action, in_box_*, in_other_*         in_valid / in_ready
// result    out_overlap                             out_valid / out_ready
// config    cfg_index, cfg_data                     cfg_we, no wait, no read-back
//
// Six register stages; a fresh word can enter on every clock unless a stalled
// output has filled the pipe. An accepted word passes stages 0 to 5 in order,
// and its result shows on out_valid, one result word per query. Each square is
// split into half-width partial products (one stage) and recombined (next stage).
// rst_n is synchronous, active low: it empties the pipe and zeroes the sphere.
// Each stage holds while the one after it is full and stalled, so a held
// result only blocks the input once every stage is occupied.

`include "sphere_volume_overlap_test_macros.svh"

module sphere_volume_overlap_test #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  logic [svot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [COORD_BITS-1:0]  in_box_low_x,
  input  logic signed [COORD_BITS-1:0]  in_box_low_y,
  input  logic signed [COORD_BITS-1:0]  in_box_low_z,
  input  logic signed [COORD_BITS-1:0]  in_box_high_x,
  input  logic signed [COORD_BITS-1:0]  in_box_high_y,
  input  logic signed [COORD_BITS-1:0]  in_box_high_z,
  input  logic signed [COORD_BITS-1:0]  in_other_x,
  input  logic signed [COORD_BITS-1:0]  in_other_y,
  input  logic signed [COORD_BITS-1:0]  in_other_z,
  input  logic [COORD_BITS-2:0]         in_other_radius,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap
);

  import svot_pkg::*;

  // Widths
  localparam int CW = COORD_BITS;      // coordinate
  localparam int AW = CW + 2;          // box slack a, b
  localparam int DW = CW + 1;          // centre difference
  localparam int LH = (CW + 1) / 2;    // low half of a squarer operand
  localparam int HH = CW - LH;         // high half
  localparam int SW = 2 * CW;          // one square
  localparam int TW = SW + 2;          // sum of three squares
  localparam int NSQ = NUM_AXES + 1;   // three axis squares plus the reference

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] cen_r [NUM_AXES];
  logic [CW-2:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cen_r[i] <= '0;
      end
      rad_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: cen_r[0] <= cfg_data;
        REG_CENTER_Y: cen_r[1] <= cfg_data;
        REG_CENTER_Z: cen_r[2] <= cfg_data;
        REG_RADIUS:   rad_r    <= cfg_data[CW-2:0];
        default:      ;
      endcase
    end
  end

  // Radius zero-extended for the slack sums
  logic signed [AW-1:0] rad_ext;
  assign rad_ext = signed'(AW'(rad_r));

  // ---------------------------------------------------------------------------
  // Flow control: a stage takes a new word when it is empty or drains
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   rdy;

  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // ---------------------------------------------------------------------------
  // Stage 0: box slacks a = r - c + high, b = r + c - low; sphere differences
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] box_lo   [NUM_AXES];
  logic signed [CW-1:0] box_hi   [NUM_AXES];
  logic signed [CW-1:0] oth      [NUM_AXES];

  assign box_lo[0] = in_box_low_x;
  assign box_lo[1] = in_box_low_y;
  assign box_lo[2] = in_box_low_z;
  assign box_hi[0] = in_box_high_x;
  assign box_hi[1] = in_box_high_y;
  assign box_hi[2] = in_box_high_z;
  assign oth[0]    = in_other_x;
  assign oth[1]    = in_other_y;
  assign oth[2]    = in_other_z;

  logic signed [AW-1:0] s0_a_nxt [NUM_AXES];
  logic signed [AW-1:0] s0_b_nxt [NUM_AXES];
  logic signed [DW-1:0] s0_d_nxt [NUM_AXES];
  logic signed [AW-1:0] s0_a_r   [NUM_AXES];
  logic signed [AW-1:0] s0_b_r   [NUM_AXES];
  logic signed [DW-1:0] s0_d_r   [NUM_AXES];
  logic                 s0_act_r;
  logic [CW-2:0]        s0_orad_r;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      s0_a_nxt[i] = rad_ext - AW'(cen_r[i]) + AW'(box_hi[i]);
      s0_b_nxt[i] = rad_ext + AW'(cen_r[i]) - AW'(box_lo[i]);
      s0_d_nxt[i] = DW'(oth[i]) - DW'(cen_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_a_r    <= s0_a_nxt;
      s0_b_r    <= s0_b_nxt;
      s0_d_r    <= s0_d_nxt;
      s0_act_r  <= in_action;
      s0_orad_r <= in_other_radius;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: separation flag, per-axis squarer operand, reference operand
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] s1_min    [NUM_AXES];
  logic signed [AW-1:0] s1_exc    [NUM_AXES];
  logic signed [DW-1:0] s1_neg    [NUM_AXES];
  logic [CW-1:0]        s1_op_nxt [NSQ];
  logic                 s1_kill_nxt;
  logic [CW-1:0]        s1_op_r   [NSQ];
  logic                 s1_kill_r;
  logic                 s1_sep;

  always_comb begin
    s1_sep = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      // touching counts as apart: a or b at or below zero separates
      s1_sep = s1_sep || s0_a_r[i][AW-1] || (s0_a_r[i] == '0)
                      || s0_b_r[i][AW-1] || (s0_b_r[i] == '0);
      s1_min[i] = (s0_a_r[i] < s0_b_r[i]) ? s0_a_r[i] : s0_b_r[i];
      s1_exc[i] = rad_ext - s1_min[i];
      s1_neg[i] = -s0_d_r[i];
      if (s0_act_r == ACT_SPHERE) begin
        s1_op_nxt[i] = s0_d_r[i][DW-1] ? s1_neg[i][CW-1:0] : s0_d_r[i][CW-1:0];
      end else begin
        // excess clamps at zero; below r when not separated
        s1_op_nxt[i] = s1_exc[i][AW-1] ? '0 : s1_exc[i][CW-1:0];
      end
    end
    s1_op_nxt[NUM_AXES] = (s0_act_r == ACT_SPHERE)
                        ? (CW'(rad_r) + CW'(s0_orad_r))
                        : CW'(rad_r);
    s1_kill_nxt = (s0_act_r == ACT_BOX) && s1_sep;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_op_r   <= s1_op_nxt;
      s1_kill_r <= s1_kill_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: half-width partial products of each square
  // ---------------------------------------------------------------------------
  logic [2*HH-1:0]    s2_hh_nxt [NSQ];
  logic [HH+LH-1:0]   s2_hl_nxt [NSQ];
  logic [2*LH-1:0]    s2_ll_nxt [NSQ];
  logic [2*HH-1:0]    s2_hh_r   [NSQ];
  logic [HH+LH-1:0]   s2_hl_r   [NSQ];
  logic [2*LH-1:0]    s2_ll_r   [NSQ];
  logic               s2_kill_r;

  always_comb begin
    for (int j = 0; j < NSQ; j++) begin
      s2_hh_nxt[j] = (2*HH)'(s1_op_r[j][CW-1:LH]) * (2*HH)'(s1_op_r[j][CW-1:LH]);
      s2_hl_nxt[j] = (HH+LH)'(s1_op_r[j][CW-1:LH]) * (HH+LH)'(s1_op_r[j][LH-1:0]);
      s2_ll_nxt[j] = (2*LH)'(s1_op_r[j][LH-1:0]) * (2*LH)'(s1_op_r[j][LH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_hh_r   <= s2_hh_nxt;
      s2_hl_r   <= s2_hl_nxt;
      s2_ll_r   <= s2_ll_nxt;
      s2_kill_r <= s1_kill_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: recombine, sq = hh * 4^LH + 2 * hl * 2^LH + ll
  // ---------------------------------------------------------------------------
  logic [SW-1:0] s3_sq_nxt [NSQ];
  logic [SW-1:0] s3_sq_r   [NSQ];
  logic          s3_kill_r;

  always_comb begin
    for (int j = 0; j < NSQ; j++) begin
      s3_sq_nxt[j] = (SW'(s2_hh_r[j]) << (2*LH))
                   + (SW'(s2_hl_r[j]) << (LH+1))
                   + SW'(s2_ll_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_sq_r   <= s3_sq_nxt;
      s3_kill_r <= s2_kill_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sum of the axis squares
  // ---------------------------------------------------------------------------
  logic [TW-1:0] s4_sum_nxt;
  logic [TW-1:0] s4_sum_r;
  logic [SW-1:0] s4_ref_r;
  logic          s4_kill_r;

  assign s4_sum_nxt = TW'(s3_sq_r[0]) + TW'(s3_sq_r[1]) + TW'(s3_sq_r[2]);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_sum_r  <= s4_sum_nxt;
      s4_ref_r  <= s3_sq_r[NUM_AXES];
      s4_kill_r <= s3_kill_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: strict compare into the output register
  // ---------------------------------------------------------------------------
  logic ovl_nxt;
  logic ovl_r;

  assign ovl_nxt = !s4_kill_r && (s4_sum_r < TW'(s4_ref_r));

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      ovl_r <= ovl_nxt;
    end
  end

  assign out_overlap = ovl_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SVOT_ASSERT_NOW(a_full_when_blocked, !in_ready, &vld_r,
    "input blocked with an empty stage in the pipe")
  `SVOT_ASSERT_NEXT(a_sep_gives_miss, vld_r[4] && rdy[5] && s4_kill_r, !out_overlap,
    "separated box reported as overlapping")
  `SVOT_ASSERT_NEXT(a_zero_ref_miss, vld_r[4] && rdy[5] && (s4_ref_r == '0), !out_overlap,
    "zero reference radius reported as overlapping")
  `SVOT_ASSERT_NEXT(a_held_stays_valid, vld_r[4] && !rdy[5], vld_r[4],
    "stalled word dropped from the pipe")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

// Bounding sphere overlap test bench.
// Directed words first (reset values, box edges, sphere edges, extreme
// configurations), then random traffic over several sphere settings. Every
// accepted query word is scored by a local predictor; the result words are
// checked in order against the queue of predicted overlap flags.
module tb_top;
  import svot_pkg::*;

  localparam int CW    = 32;
  localparam int LIMIT = 1_000_000;

  // Q16.16 handy values
  localparam logic [CW-1:0] ONE  = 32'h0001_0000;
  localparam logic [CW-1:0] HALF = 32'h0000_8000;
  localparam logic [CW-1:0] PT6  = 32'h0000_999a;
  localparam logic [CW-1:0] CMIN = 32'h8000_0000;
  localparam logic [CW-1:0] CMAX = 32'h7fff_ffff;
  localparam logic [CW-2:0] RMAX = '1;

  // one query word, held as raw port bits
  typedef struct packed {
    logic          action;
    logic [CW-1:0] box_lo_x, box_lo_y, box_lo_z;
    logic [CW-1:0] box_hi_x, box_hi_y, box_hi_z;
    logic [CW-1:0] oth_x, oth_y, oth_z;
    logic [CW-2:0] oth_r;
  } query_t;

  // predicted result, tagged with the query number for the log
  typedef struct {
    int unsigned seq;
    logic        hit;
  } hit_exp_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  cfg_reg_t      cfg_index = REG_CENTER_X;
  logic [CW-1:0] cfg_data = '0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_action = ACT_BOX;
  logic [CW-1:0] in_box_low_x = '0, in_box_low_y = '0, in_box_low_z = '0;
  logic [CW-1:0] in_box_high_x = '0, in_box_high_y = '0, in_box_high_z = '0;
  logic [CW-1:0] in_other_x = '0, in_other_y = '0, in_other_z = '0;
  logic [CW-2:0] in_other_radius = '0;

  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_overlap;

  // local copy of the sphere registers, reset values
  logic [CW-1:0] sph_cx = '0, sph_cy = '0, sph_cz = '0;
  logic [CW-2:0] sph_r = '0;

  hit_exp_t      hit_q[$];
  int unsigned   sent_cnt = 0;
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  int            stall_left = 0;
  bit            idle_on = 1'b0;   // random gaps and stalls enabled

  sphere_volume_overlap_test #(
    .COORD_BITS (CW)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_box_low_x    (in_box_low_x),
    .in_box_low_y    (in_box_low_y),
    .in_box_low_z    (in_box_low_z),
    .in_box_high_x   (in_box_high_x),
    .in_box_high_y   (in_box_high_y),
    .in_box_high_z   (in_box_high_z),
    .in_other_x      (in_other_x),
    .in_other_y      (in_other_y),
    .in_other_z      (in_other_z),
    .in_other_radius (in_other_radius),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_overlap     (out_overlap)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Everything is lifted into 64-bit signed values, so differences
  // are exact; squares and their sums live in 128 bits and never wrap.
  // ---------------------------------------------------------------------------

  function automatic logic [127:0] sq128(longint v);
    logic [127:0] w;
    w = {64'd0, v};
    return w * w;
  endfunction

  function automatic logic [127:0] sq_dist(longint a, longint b);
    longint d;
    d = a - b;
    return sq128((d < 0) ? -d : d);
  endfunction

  // Gap from the centre to the box on one axis (clamped at zero). The box is
  // apart on this axis when either reach is zero or less - touching is apart.
  // Corners are used as given, so an inverted box goes through the same sums.
  function automatic longint slab_gap(longint c, longint r, longint lo, longint hi,
                                      output bit apart);
    longint a, b, m;
    a = r - c + hi;
    b = r + c - lo;
    apart = (a <= 0) || (b <= 0);
    m = (a < b) ? a : b;
    return (r > m) ? r - m : 0;
  endfunction

  function automatic logic predict_overlap(input query_t q);
    longint       cx, cy, cz, r, gx, gy, gz, rs;
    bit           ax, ay, az;
    logic [127:0] d2;
    cx = longint'($signed(sph_cx));
    cy = longint'($signed(sph_cy));
    cz = longint'($signed(sph_cz));
    r  = longint'(sph_r);
    if (q.action == ACT_BOX) begin
      gx = slab_gap(cx, r, longint'($signed(q.box_lo_x)), longint'($signed(q.box_hi_x)), ax);
      gy = slab_gap(cy, r, longint'($signed(q.box_lo_y)), longint'($signed(q.box_hi_y)), ay);
      gz = slab_gap(cz, r, longint'($signed(q.box_lo_z)), longint'($signed(q.box_hi_z)), az);
      d2 = sq128(gx) + sq128(gy) + sq128(gz);
      return !(ax || ay || az) && (d2 < sq128(r));
    end
    // sphere query: strict compare, so two zero radii never overlap
    rs = r + longint'(q.oth_r);
    d2 = sq_dist(longint'($signed(q.oth_x)), cx) + sq_dist(longint'($signed(q.oth_y)), cy)
       + sq_dist(longint'($signed(q.oth_z)), cz);
    return d2 < sq128(rs);
  endfunction

  // ---------------------------------------------------------------------------
  // Query builders. Fields of the mode not selected are always random.
  // ---------------------------------------------------------------------------

  function automatic query_t rand_query();
    query_t q;
    q.action   = 1'($urandom);
    q.box_lo_x = $urandom;
    q.box_lo_y = $urandom;
    q.box_lo_z = $urandom;
    q.box_hi_x = $urandom;
    q.box_hi_y = $urandom;
    q.box_hi_z = $urandom;
    q.oth_x    = $urandom;
    q.oth_y    = $urandom;
    q.oth_z    = $urandom;
    q.oth_r    = 31'($urandom);
    return q;
  endfunction

  function automatic query_t box_q(logic [CW-1:0] lx, ly, lz, hx, hy, hz);
    query_t q;
    q = rand_query();
    q.action   = ACT_BOX;
    q.box_lo_x = lx;
    q.box_lo_y = ly;
    q.box_lo_z = lz;
    q.box_hi_x = hx;
    q.box_hi_y = hy;
    q.box_hi_z = hz;
    return q;
  endfunction

  function automatic query_t sphere_q(logic [CW-1:0] x, y, z, logic [CW-2:0] rad);
    query_t q;
    q = rand_query();
    q.action = ACT_SPHERE;
    q.oth_x  = x;
    q.oth_y  = y;
    q.oth_z  = z;
    q.oth_r  = rad;
    return q;
  endfunction

  // coordinate within span of c, clamped to the Q16.16 range
  function automatic logic [CW-1:0] near(logic [CW-1:0] c, longint span);
    longint v;
    v = longint'($signed(c)) + longint'({$urandom, $urandom} % (2 * span + 1)) - span;
    if (v > longint'($signed(CMAX)))
      v = longint'($signed(CMAX));
    if (v < longint'($signed(CMIN)))
      v = longint'($signed(CMIN));
    return v[CW-1:0];
  endfunction

  // mostly put corners in order; leave about one in five inverted
  function automatic void order_pair(inout logic [CW-1:0] lo, inout logic [CW-1:0] hi);
    logic [CW-1:0] t;
    if ($signed(lo) > $signed(hi) && $urandom_range(0, 4) != 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Valid stays up across back-to-back words; it only drops for a
  // gap, a drain or the end of the run.
  // ---------------------------------------------------------------------------

  task automatic send_query(input query_t q);
    int gap;
    int roll;
    gap = 0;
    if (idle_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 93)
        gap = $urandom_range(10, 40);
      else if (roll >= 60)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= q.action;
    in_box_low_x    <= q.box_lo_x;
    in_box_low_y    <= q.box_lo_y;
    in_box_low_z    <= q.box_lo_z;
    in_box_high_x   <= q.box_hi_x;
    in_box_high_y   <= q.box_hi_y;
    in_box_high_z   <= q.box_hi_z;
    in_other_x      <= q.oth_x;
    in_other_y      <= q.oth_y;
    in_other_z      <= q.oth_z;
    in_other_radius <= q.oth_r;
    do @(posedge clk); while (!in_ready);
    // word taken at this edge; score it against the current sphere
    hit_q.push_back('{sent_cnt, predict_overlap(q)});
    sent_cnt++;
  endtask

  // drop valid, wait for every predicted result, then let the pipe empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (hit_q.size() != 0)
      @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  // Rewrites all four sphere registers, only with the block idle. The top
  // data bit sits above the radius register, so it is toggled at random to
  // show that it is dropped.
  task automatic load_sphere(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                             input logic [CW-1:0] cz, input logic [CW-2:0] r);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CENTER_X;
    cfg_data  <= cx;
    @(posedge clk);
    cfg_index <= REG_CENTER_Y;
    cfg_data  <= cy;
    @(posedge clk);
    cfg_index <= REG_CENTER_Z;
    cfg_data  <= cz;
    @(posedge clk);
    cfg_index <= REG_RADIUS;
    cfg_data  <= {1'($urandom), r};
    @(posedge clk);
    cfg_we <= 1'b0;
    sph_cx = cx;
    sph_cy = cy;
    sph_cz = cz;
    sph_r  = r;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking.
  // ---------------------------------------------------------------------------

  // mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 12) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    hit_exp_t head;
    if (rst_n && out_valid && out_ready) begin
      if (hit_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("[%0t] result word with no query pending: overlap=%b",
                   $time, out_overlap);
      end else begin
        head = hit_q.pop_front();
        if (out_overlap !== head.hit) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] query %0d overlap: expected %b, got %b",
                     $time, head.seq, head.hit, out_overlap);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // registers straight out of reset: zero centre, zero radius
  task automatic test_reset_values();
    idle_on = 1'b0;
    send_query(box_q(-ONE, -ONE, -ONE, ONE, ONE, ONE));   // zero radius box: never
    send_query(sphere_q('0, '0, '0, '0));                  // both radii zero
    send_query(sphere_q('0, '0, '0, 31'd1));               // one ulp of radius
    send_query(sphere_q(CMAX, CMAX, CMAX, RMAX));
  endtask

  // unit sphere at the origin against boxes on and around its edge
  task automatic test_box_edges();
    load_sphere('0, '0, '0, ONE[CW-2:0]);
    idle_on = 1'b1;
    send_query(box_q(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_query(box_q(ONE, -ONE, -ONE, 2 * ONE, ONE, ONE));        // touching in x
    send_query(box_q(ONE - 1, -ONE, -ONE, 2 * ONE, ONE, ONE));    // just inside
    send_query(box_q(-ONE, -2 * ONE, -ONE, ONE, -ONE, ONE));      // touching below y
    send_query(box_q(PT6, PT6, PT6, 2 * ONE, 2 * ONE, 2 * ONE));  // corner, outside
    send_query(box_q(HALF, HALF, HALF, 2 * ONE, 2 * ONE, 2 * ONE));
    send_query(box_q(-ONE, -ONE, HALF, ONE, ONE, -HALF));         // inverted in z
    send_query(box_q(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_query(box_q(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
  endtask

  // radius 3 at the origin: touching spheres are apart
  task automatic test_sphere_edges();
    load_sphere('0, '0, '0, 31'(3 * ONE));
    send_query(sphere_q(5 * ONE, '0, '0, 31'(2 * ONE)));
    send_query(sphere_q(5 * ONE, '0, '0, 31'(2 * ONE + 1)));
    send_query(sphere_q('0, '0, '0, '0));
    send_query(sphere_q(CMIN, CMIN, CMIN, RMAX));
  endtask

  // centre pinned to either end of the range, radius at both extremes
  task automatic test_config_extremes();
    load_sphere(CMIN, CMIN, CMIN, RMAX);
    send_query(sphere_q(CMAX, CMAX, CMAX, RMAX));
    send_query(box_q(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_query(box_q(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    load_sphere(CMAX, CMAX, CMAX, '0);
    send_query(sphere_q(CMAX, CMAX, CMAX, '0));
    send_query(sphere_q(CMAX, CMAX, CMAX, 31'd1));
    send_query(box_q(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
  endtask

  // Eight sphere settings. Most words sit near the sphere so that both
  // answers come up often; the rest are fully random. Two settings run
  // without gaps or stalls.
  task automatic test_random_traffic();
    logic [CW-1:0] cx, cy, cz;
    logic [CW-2:0] r;
    longint        span;
    query_t        q;
    for (int phase = 0; phase < 8; phase++) begin
      cx = $urandom;
      cy = $urandom;
      cz = $urandom;
      case ($urandom_range(0, 2))
        0:       r = 31'($urandom_range(0, 'hffff));
        1:       r = 31'($urandom_range(0, 'hff_ffff));
        default: r = 31'($urandom);
      endcase
      case (phase)
        0: begin
          cx = near('0, 'h10_0000);
          cy = near('0, 'h10_0000);
          cz = near('0, 'h10_0000);
          r  = 31'($urandom_range(0, 'h4_0000));
        end
        1: r = '0;
        2: begin
          cx = CMIN;
          cy = CMIN;
          cz = CMIN;
          r  = RMAX;
        end
        3: begin
          cx = CMAX;
          cy = CMAX;
          cz = CMAX;
        end
        default: ;
      endcase
      load_sphere(cx, cy, cz, r);
      idle_on = !(phase == 2 || phase == 5);
      span = longint'(r) * 2 + 16;
      repeat (180) begin
        q = rand_query();
        if ($urandom_range(0, 9) >= 3) begin
          q.box_lo_x = near(cx, span);
          q.box_hi_x = near(cx, span);
          q.box_lo_y = near(cy, span);
          q.box_hi_y = near(cy, span);
          q.box_lo_z = near(cz, span);
          q.box_hi_z = near(cz, span);
          order_pair(q.box_lo_x, q.box_hi_x);
          order_pair(q.box_lo_y, q.box_hi_y);
          order_pair(q.box_lo_z, q.box_hi_z);
          q.oth_x = near(cx, span);
          q.oth_y = near(cy, span);
          q.oth_z = near(cz, span);
          q.oth_r = 31'({$urandom, $urandom} % span);
        end
        send_query(q);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_box_edges();
    test_sphere_edges();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    if (err_cnt == 0 && hit_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/svot_pkg.sv
hw/rtl/sphere_volume_overlap_test.sv
dv/tb_top.sv
